// ===== rtl/core/sbs_pkg.sv =====
// ----------------------------------------------------------------------------
// sbs_pkg: shared types and constants for the sorted table bound search
// Mode codes, queue word layout, search configuration and engine states.
// ----------------------------------------------------------------------------
package sbs_pkg;

	localparam int DATA_W = 64;  // width of value and key ports
	localparam int IDX_W  = 10;  // width of entry_index port
	localparam int POS_W  = 11;  // width of table_size and position

	// input mode codes
	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_LOWER = 2'd1;
	localparam logic [1:0] MODE_UPPER = 2'd2;

	typedef enum logic [1:0] {
		KIND_WRITE,
		KIND_LOWER,
		KIND_UPPER
	} item_kind_t;

	// one classified word between front and engine
	typedef struct packed {
		item_kind_t         kind;
		logic [IDX_W-1:0]   idx;
		logic [DATA_W-1:0]  value;  // entry value on a write, key on a query
	} word_t;

	// effective table size and first probe slot (largest 2^k minus one)
	typedef struct packed {
		logic [POS_W-1:0] n;
		logic [POS_W-1:0] size;
	} search_cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FIRST,
		ST_STEP,
		ST_DONE
	} eng_state_t;

endpackage

// ===== rtl/core/sbs_ram.sv =====
// ----------------------------------------------------------------------------
// sbs_ram: generic single-port RAM
// One write or read address per cycle, registered read data.
// ----------------------------------------------------------------------------
module sbs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ===== rtl/core/sbs_front.sv =====
// ----------------------------------------------------------------------------
// sbs_front: input stage
// Accepts words, classifies them, drops unused modes and out-of-range writes.
// ----------------------------------------------------------------------------
module sbs_front #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 mode,
	input  logic [sbs_pkg::IDX_W-1:0]  entry_index,
	input  logic [sbs_pkg::DATA_W-1:0] entry_value,
	input  logic [sbs_pkg::DATA_W-1:0] search_key,
	output logic                       push,
	output sbs_pkg::word_t             push_word,
	input  logic                       q_full
);
	import sbs_pkg::*;

	logic  valid_s1;
	word_t word_s1;
	word_t word_c;
	logic  keep_c;

	always_comb begin
		word_c.idx   = entry_index;
		word_c.value = search_key;
		word_c.kind  = KIND_LOWER;
		keep_c       = 1'b1;
		unique case (mode)
			MODE_WRITE: begin
				word_c.kind  = KIND_WRITE;
				word_c.value = entry_value;
				keep_c       = (32'(entry_index) < TABLE_DEPTH);
			end
			MODE_LOWER: word_c.kind = KIND_LOWER;
			MODE_UPPER: word_c.kind = KIND_UPPER;
			default:    keep_c = 1'b0;
		endcase
	end

	assign in_stall  = valid_s1 && q_full;
	assign push      = valid_s1 && !q_full;
	assign push_word = word_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid && keep_c;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			word_s1 <= word_c;
		end
	end

endmodule

// ===== rtl/core/sbs_queue.sv =====
// ----------------------------------------------------------------------------
// sbs_queue: short FIFO between front and engine
// Register storage, head word shown while not empty.
// ----------------------------------------------------------------------------
module sbs_queue #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sbs_pkg::word_t push_word,
	output logic           full,
	output logic           head_valid,
	output sbs_pkg::word_t head_word,
	input  logic           pop
);
	import sbs_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	word_t         mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_word  = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

endmodule

// ===== rtl/core/sbs_engine.sv =====
// ----------------------------------------------------------------------------
// sbs_engine: table writes and bound search
// Owns the table RAM; one probe per cycle, result held in an output register.
// ----------------------------------------------------------------------------
module sbs_engine #(
	parameter int TABLE_DEPTH = 1024,
	parameter int KEY_WIDTH   = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sbs_pkg::search_cfg_t      cfg,
	input  logic                      head_valid,
	input  sbs_pkg::word_t            head_word,
	output logic                      pop,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [sbs_pkg::POS_W-1:0] position
);
	import sbs_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	eng_state_t            state_q;
	eng_state_t            state_d;
	logic [POS_W-1:0]      off_q;
	logic [POS_W-1:0]      off_d;
	logic [POS_W-1:0]      k_q;
	logic [POS_W-1:0]      k_d;
	logic                  ld_walk;
	logic                  ld_key;
	logic                  ld_out;
	logic [KEY_WIDTH-1:0]  key_q;
	logic                  upper_q;
	logic                  out_valid_q;
	logic [POS_W-1:0]      position_q;

	logic                  ram_we;
	logic [AW-1:0]         ram_addr;
	logic [KEY_WIDTH-1:0]  ram_wdata;
	logic [KEY_WIDTH-1:0]  ram_rdata;

	logic signed [KEY_WIDTH-1:0] entry_s;
	logic signed [KEY_WIDTH-1:0] key_s;
	logic                        hit;

	sbs_ram #(
		.WIDTH (KEY_WIDTH),
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// probe true: entry not below key (lower) / entry above key (upper)
	assign entry_s = ram_rdata;
	assign key_s   = key_q;
	assign hit     = upper_q ? (entry_s > key_s) : (entry_s >= key_s);

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = AW'(head_word.idx);
		ram_wdata = head_word.value[KEY_WIDTH-1:0];
		off_d     = off_q;
		k_d       = k_q;
		ld_walk   = 1'b0;
		ld_key    = 1'b0;
		ld_out    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (head_valid) begin
					pop = 1'b1;
					if (head_word.kind == KIND_WRITE) begin
						ram_we = 1'b1;
					end else begin
						ram_addr = AW'(cfg.size);
						ld_key   = 1'b1;
						state_d  = ST_FIRST;
					end
				end
			end
			ST_FIRST: begin
				// first probe picks prefix or overlapping suffix
				off_d    = hit ? '0 : cfg.n - cfg.size;
				k_d      = cfg.size >> 1;
				ram_addr = AW'(off_d + k_d);
				ld_walk  = 1'b1;
				state_d  = (cfg.size == '0) ? ST_DONE : ST_STEP;
			end
			ST_STEP: begin
				off_d    = hit ? off_q : off_q + k_q + 1'b1;
				k_d      = k_q >> 1;
				ram_addr = AW'(off_d + k_d);
				ld_walk  = 1'b1;
				state_d  = (k_q == '0) ? ST_DONE : ST_STEP;
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					ld_out  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_key) begin
			key_q   <= head_word.value[KEY_WIDTH-1:0];
			upper_q <= (head_word.kind == KIND_UPPER);
		end
		if (ld_walk) begin
			off_q <= off_d;
			k_q   <= k_d;
		end
		if (ld_out) begin
			position_q <= off_q;
		end
	end

	assign out_valid = out_valid_q;
	assign position  = position_q;

endmodule

// ===== rtl/core/sorted_table_bound_search.sv =====
// ----------------------------------------------------------------------------
// sorted_table_bound_search: lower/upper bound search over a sorted table
// Stores signed entries in a RAM and answers bound queries with a fixed
// branchless probe sequence, one probe per cycle.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+-------------------------------------
//  in      | to block  | in_valid/in_stall  | mode, entry_index, entry_value, key
//  out     | from block| out_valid/out_stall| position
//  cfg     | to block  | cfg_valid/cfg_ready| cfg_data = table_size
//
// A write word is written to the RAM as the engine takes it. A query
// issues the first RAM read, makes m+1 compares, m = floor(log2(table_size)),
// one per probe, paced by the single RAM read port, then loads the result
// register. Front stage and a 2-word queue sit ahead of the engine and keep
// accepting while the engine searches, until the queue is full.
// arst_n clears control only; table contents are undefined until written,
// table_size resets to 1. cfg_ready is always high.
// in_stall rises only when the front stage holds a word and the queue is
// full; a stalled result waits in the output register.
module sorted_table_bound_search #(
	parameter int TABLE_DEPTH = 1024,
	parameter int KEY_WIDTH   = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 mode,
	input  logic [sbs_pkg::IDX_W-1:0]  entry_index,
	input  logic [sbs_pkg::DATA_W-1:0] entry_value,
	input  logic [sbs_pkg::DATA_W-1:0] search_key,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [sbs_pkg::POS_W-1:0]  position,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [sbs_pkg::POS_W-1:0]  cfg_data
);
	import sbs_pkg::*;

	search_cfg_t      cfg_q;
	logic [POS_W-1:0] n_c;
	logic [POS_W-1:0] pow_c;
	logic             push;
	word_t            push_word;
	logic             q_full;
	logic             head_valid;
	word_t            head_word;
	logic             pop;

	assign cfg_ready = 1'b1;

	// effective size: zero reads as one, saturate at table depth
	always_comb begin
		n_c = cfg_data;
		if (cfg_data == '0) begin
			n_c = POS_W'(1);
		end else if (32'(cfg_data) > TABLE_DEPTH) begin
			n_c = POS_W'(TABLE_DEPTH);
		end
		// largest power of two not above n
		pow_c = POS_W'(1);
		for (int i = 0; i < POS_W; i++) begin
			if (n_c[i]) begin
				pow_c = POS_W'(1) << i;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.n    <= POS_W'(1);
			cfg_q.size <= '0;
		end else if (cfg_valid && cfg_ready) begin
			cfg_q.n    <= n_c;
			cfg_q.size <= pow_c - 1'b1;
		end
	end

	sbs_front #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.search_key  (search_key),
		.push        (push),
		.push_word   (push_word),
		.q_full      (q_full)
	);

	sbs_queue #(
		.DEPTH (2)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_word  (push_word),
		.full       (q_full),
		.head_valid (head_valid),
		.head_word  (head_word),
		.pop        (pop)
	);

	sbs_engine #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.KEY_WIDTH   (KEY_WIDTH)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_word  (head_word),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.position   (position)
	);

endmodule

// ===== rtl/core/sbs_checker.sv =====
// ----------------------------------------------------------------------------
// sbs_checker: port-level checks for the bound search block
// Tracks queries in flight against results delivered.
// ----------------------------------------------------------------------------
module sbs_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic [1:0]                 mode,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [sbs_pkg::POS_W-1:0]  position,
	input logic                       cfg_valid,
	input logic                       cfg_ready
);
	import sbs_pkg::*;

	logic [2:0] pending_q;
	logic       q_acc;
	logic       r_acc;

	assign q_acc = in_valid && !in_stall && (mode == MODE_LOWER || mode == MODE_UPPER);
	assign r_acc = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (q_acc && !r_acc) begin
			pending_q <= pending_q + 1'b1;
		end else if (r_acc && !q_acc) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(position))
		else $error("result changed while stalled");

	// no result without a query behind it
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 3'd0)
		else $error("result without pending query");

	// front stage, queue, engine and output register bound the queries in flight
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd5)
		else $error("too many queries in flight");

	// position never passes the table depth limit
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> position <= 11'd1024)
		else $error("position out of range");

	// the config port never blocks
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write refused");

endmodule

bind sorted_table_bound_search sbs_checker u_sbs_checker (.*);
